>>> rtl/gcs_pkg.sv
// Shared types and constants for the guide correction solver.
// No dependencies; compiled first.
package gcs_pkg;

   localparam int WORD_W  = 32;   // Q-format word
   localparam int PROD_W  = 64;   // 32x32 signed product
   localparam int MAG_W   = 64;   // magnitude of a numerator or determinant
   localparam int REM_W   = 65;   // divider remainder, one spare bit
   localparam int DIV_Q_W = 33;   // quotient bits kept; more is saturation
   localparam int SAT_W   = 68;   // widest intermediate before saturation
   localparam int NUM_COEF = 6;

   typedef logic [1:0] status_type;
   localparam status_type STATUS_OK     = 2'd0;
   localparam status_type STATUS_NO_CAL = 2'd1;
   localparam status_type STATUS_SAT    = 2'd2;

   typedef logic [2:0] csr_index_type;
   localparam csr_index_type CSR_COEF_RA_X    = 3'd0;
   localparam csr_index_type CSR_COEF_DEC_X   = 3'd1;
   localparam csr_index_type CSR_DRIFT_RATE_X = 3'd2;
   localparam csr_index_type CSR_COEF_RA_Y    = 3'd3;
   localparam csr_index_type CSR_COEF_DEC_Y   = 3'd4;
   localparam csr_index_type CSR_DRIFT_RATE_Y = 3'd5;
   localparam csr_index_type CSR_FLIP_SIGN    = 3'd6;

   localparam logic signed [SAT_W-1:0] SAT_MAX =
      {{(SAT_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
   localparam logic signed [SAT_W-1:0] SAT_MIN =
      {{(SAT_W-WORD_W+1){1'b1}}, {(WORD_W-1){1'b0}}};

   // One lane of the restoring divider
   typedef struct packed {
      logic [REM_W-1:0]   rem;
      logic [DIV_Q_W-1:0] quo;
      logic [DIV_Q_W-1:0] low;   // dividend bits still to shift in
      logic               ovf;
      logic               neg;
   } div_lane_type;

   // Payload that rides alongside the divider
   typedef struct packed {
      logic              func;
      logic              det_zero;
      logic              sat_pre;
      logic [WORD_W-1:0] off_x;
      logic [WORD_W-1:0] off_y;
      logic              off_sat;
      logic [MAG_W-1:0]  den;
   } side_type;

   // Saturate to a word: {flag, value}
   function automatic logic [WORD_W:0] sat_word(input logic signed [SAT_W-1:0] v);
      logic [WORD_W:0] r;
      if (v > SAT_MAX) begin
         r = {1'b1, SAT_MAX[WORD_W-1:0]};
      end else if (v < SAT_MIN) begin
         r = {1'b1, SAT_MIN[WORD_W-1:0]};
      end else begin
         r = {1'b0, v[WORD_W-1:0]};
      end
      return r;
   endfunction

endpackage

>>> rtl/gcs_if.sv
// Channel interfaces for the guide correction solver: request, response, CSR.
// Depends on gcs_pkg.
interface gcs_req_if;
   logic                             valid;
   logic                             ready;
   logic                             func;
   logic signed [gcs_pkg::WORD_W-1:0] point_x;
   logic signed [gcs_pkg::WORD_W-1:0] point_y;
   logic signed [gcs_pkg::WORD_W-1:0] time_span;
   modport source(output valid, func, point_x, point_y, time_span, input ready);
   modport sink(input valid, func, point_x, point_y, time_span, output ready);
endinterface

interface gcs_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [gcs_pkg::WORD_W-1:0] result_x;
   logic signed [gcs_pkg::WORD_W-1:0] result_y;
   gcs_pkg::status_type              status;
   modport source(output valid, result_x, result_y, status, input ready);
   modport sink(input valid, result_x, result_y, status, output ready);
endinterface

interface gcs_csr_if;
   logic                        valid;
   logic                        ready;
   gcs_pkg::csr_index_type      index;
   logic [gcs_pkg::WORD_W-1:0]  data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

>>> rtl/guide_correction_solver.sv
// Guide correction solver top level: CSR bank, multiply stages and divider pipeline.
// Depends on gcs_pkg and the channel interfaces in gcs_if.sv.
//
//   channel  | dir | payload                              | accepted when
//   ---------+-----+--------------------------------------+---------------------
//   req_bus  | in  | func, point_x, point_y, time_span    | valid && ready
//   rsp_bus  | out | result_x, result_y, status           | valid && ready
//   csr_bus  | in  | index (0..6), data                   | valid && ready
//
// One request per cycle while the response side does not stall; the path runs
// through four multiply/add stages, the divider set-up stage, the 33 steps of
// the restoring divider and the output register.
// Reset clears the calibration registers and all valid bits.
// A stall on the response side freezes every stage at once; req_bus.ready
// drops in the same cycle, so nothing is lost or repeated.
// CSR writes are taken every cycle and must only happen while idle.
module guide_correction_solver #(
   parameter int FRAC_BITS = 16
) (
   input  logic     clock,
   input  logic     reset,
   gcs_req_if.sink   req_bus,
   gcs_rsp_if.source rsp_bus,
   gcs_csr_if.sink   csr_bus
);
   import gcs_pkg::*;

   localparam int DIV_STEPS = DIV_Q_W;
   localparam int DVD_W     = MAG_W + FRAC_BITS;   // numerator scaled by 2^FRAC_BITS
   localparam int HI_W      = DVD_W - DIV_Q_W;

   // ---------------- calibration registers ----------------
   logic signed [WORD_W-1:0] coef_ff [NUM_COEF];
   logic                     flip_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_COEF; i++) coef_ff[i] <= '0;
         flip_ff <= 1'b0;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_FLIP_SIGN: flip_ff <= csr_bus.data[0];
            default: begin
               // drop writes beyond the register list
               if (csr_bus.index < csr_index_type'(NUM_COEF))
                  coef_ff[csr_bus.index] <= csr_bus.data;
            end
         endcase
      end
   end

   logic signed [WORD_W-1:0] a0, a1, a2, a3, a4, a5;
   assign a0 = coef_ff[CSR_COEF_RA_X];
   assign a1 = coef_ff[CSR_COEF_DEC_X];
   assign a2 = coef_ff[CSR_DRIFT_RATE_X];
   assign a3 = coef_ff[CSR_COEF_RA_Y];
   assign a4 = coef_ff[CSR_COEF_DEC_Y];
   assign a5 = coef_ff[CSR_DRIFT_RATE_Y];

   // Advance the whole pipeline when the output register is free or drains.
   logic out_valid_ff;
   logic adv;
   assign adv           = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready = adv;

   // ---------------- stage 1: raw products ----------------
   logic                     s1_valid_ff, s1_func_ff;
   logic signed [WORD_W-1:0] s1_px_ff, s1_py_ff;
   logic signed [PROD_W-1:0] s1_deta_ff, s1_detb_ff, s1_tx_ff, s1_ty_ff;
   logic signed [PROD_W-1:0] s1_ox0_ff, s1_ox1_ff, s1_oy0_ff, s1_oy1_ff;

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else if (adv) s1_valid_ff <= req_bus.valid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_func_ff <= req_bus.func;
         s1_px_ff   <= req_bus.point_x;
         s1_py_ff   <= req_bus.point_y;
         s1_deta_ff <= PROD_W'(a0) * PROD_W'(a4);
         s1_detb_ff <= PROD_W'(a1) * PROD_W'(a3);
         s1_tx_ff   <= PROD_W'(req_bus.time_span) * PROD_W'(a2);
         s1_ty_ff   <= PROD_W'(req_bus.time_span) * PROD_W'(a5);
         s1_ox0_ff  <= PROD_W'(a0) * PROD_W'(req_bus.point_x);
         s1_ox1_ff  <= PROD_W'(a1) * PROD_W'(req_bus.point_y);
         s1_oy0_ff  <= PROD_W'(a3) * PROD_W'(req_bus.point_x);
         s1_oy1_ff  <= PROD_W'(a4) * PROD_W'(req_bus.point_y);
      end
   end

   // ---------------- stage 2: drift removal, determinant, forward model ---
   logic signed [WORD_W:0]   neg_px, neg_py;
   logic signed [SAT_W-1:0]  dx_full, dy_full, offx_sum, offy_sum;
   logic [WORD_W:0]          dx_sat, dy_sat, offx_sat, offy_sat;
   logic signed [PROD_W:0]   det_in;

   always_comb begin
      // -(s*p): flipped mount keeps the sign, normal mount negates
      neg_px   = flip_ff ? (WORD_W+1)'(s1_px_ff) : -(WORD_W+1)'(s1_px_ff);
      neg_py   = flip_ff ? (WORD_W+1)'(s1_py_ff) : -(WORD_W+1)'(s1_py_ff);
      dx_full  = ((SAT_W'(neg_px) <<< FRAC_BITS) - SAT_W'(s1_tx_ff)) >>> FRAC_BITS;
      dy_full  = ((SAT_W'(neg_py) <<< FRAC_BITS) - SAT_W'(s1_ty_ff)) >>> FRAC_BITS;
      offx_sum = SAT_W'(s1_ox0_ff) + SAT_W'(s1_ox1_ff) + SAT_W'(s1_tx_ff);
      offy_sum = SAT_W'(s1_oy0_ff) + SAT_W'(s1_oy1_ff) + SAT_W'(s1_ty_ff);
      if (flip_ff) begin
         offx_sum = -offx_sum;
         offy_sum = -offy_sum;
      end
      offx_sum = offx_sum >>> FRAC_BITS;
      offy_sum = offy_sum >>> FRAC_BITS;
      dx_sat   = sat_word(dx_full);
      dy_sat   = sat_word(dy_full);
      offx_sat = sat_word(offx_sum);
      offy_sat = sat_word(offy_sum);
      det_in   = (PROD_W+1)'(s1_deta_ff) - (PROD_W+1)'(s1_detb_ff);
   end

   logic                     s2_valid_ff, s2_func_ff, s2_satd_ff, s2_sato_ff;
   logic signed [PROD_W:0]   s2_det_ff;
   logic signed [WORD_W-1:0] s2_dx_ff, s2_dy_ff;
   logic [WORD_W-1:0]        s2_offx_ff, s2_offy_ff;

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else if (adv) s2_valid_ff <= s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_func_ff <= s1_func_ff;
         s2_det_ff  <= det_in;
         s2_dx_ff   <= dx_sat[WORD_W-1:0];
         s2_dy_ff   <= dy_sat[WORD_W-1:0];
         s2_satd_ff <= dx_sat[WORD_W] | dy_sat[WORD_W];
         s2_offx_ff <= offx_sat[WORD_W-1:0];
         s2_offy_ff <= offy_sat[WORD_W-1:0];
         s2_sato_ff <= offx_sat[WORD_W] | offy_sat[WORD_W];
      end
   end

   // ---------------- stage 3: Cramer products ----------------
   logic                     s3_valid_ff, s3_func_ff, s3_satd_ff, s3_sato_ff;
   logic signed [PROD_W:0]   s3_det_ff;
   logic signed [PROD_W-1:0] s3_a4dx_ff, s3_a1dy_ff, s3_a0dy_ff, s3_a3dx_ff;
   logic [WORD_W-1:0]        s3_offx_ff, s3_offy_ff;

   always_ff @(posedge clock) begin
      if (reset) s3_valid_ff <= 1'b0;
      else if (adv) s3_valid_ff <= s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_func_ff <= s2_func_ff;
         s3_det_ff  <= s2_det_ff;
         s3_satd_ff <= s2_satd_ff;
         s3_sato_ff <= s2_sato_ff;
         s3_offx_ff <= s2_offx_ff;
         s3_offy_ff <= s2_offy_ff;
         s3_a4dx_ff <= PROD_W'(a4) * PROD_W'(s2_dx_ff);
         s3_a1dy_ff <= PROD_W'(a1) * PROD_W'(s2_dy_ff);
         s3_a0dy_ff <= PROD_W'(a0) * PROD_W'(s2_dy_ff);
         s3_a3dx_ff <= PROD_W'(a3) * PROD_W'(s2_dx_ff);
      end
   end

   // ---------------- stage 4: numerators to sign and magnitude ----------
   logic signed [PROD_W:0] num_x, num_y, det_abs, numx_abs, numy_abs;

   always_comb begin
      num_x    = (PROD_W+1)'(s3_a4dx_ff) - (PROD_W+1)'(s3_a1dy_ff);
      num_y    = (PROD_W+1)'(s3_a0dy_ff) - (PROD_W+1)'(s3_a3dx_ff);
      numx_abs = num_x[PROD_W] ? -num_x : num_x;
      numy_abs = num_y[PROD_W] ? -num_y : num_y;
      det_abs  = s3_det_ff[PROD_W] ? -s3_det_ff : s3_det_ff;
   end

   logic             s4_valid_ff, s4_negx_ff, s4_negy_ff;
   logic [MAG_W-1:0] s4_nx_ff, s4_ny_ff;
   side_type         s4_side_ff;

   always_ff @(posedge clock) begin
      if (reset) s4_valid_ff <= 1'b0;
      else if (adv) s4_valid_ff <= s3_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_nx_ff            <= numx_abs[MAG_W-1:0];
         s4_ny_ff            <= numy_abs[MAG_W-1:0];
         s4_negx_ff          <= num_x[PROD_W] ^ s3_det_ff[PROD_W];
         s4_negy_ff          <= num_y[PROD_W] ^ s3_det_ff[PROD_W];
         s4_side_ff.func     <= s3_func_ff;
         s4_side_ff.det_zero <= (s3_det_ff == '0);
         s4_side_ff.sat_pre  <= s3_satd_ff;
         s4_side_ff.off_x    <= s3_offx_ff;
         s4_side_ff.off_y    <= s3_offy_ff;
         s4_side_ff.off_sat  <= s3_sato_ff;
         s4_side_ff.den      <= det_abs[MAG_W-1:0];
      end
   end

   // ---------------- stage 5: divider set-up, overflow check ------------
   logic [DVD_W-1:0] dvd_x, dvd_y;
   logic [HI_W-1:0]  hi_x, hi_y;
   div_lane_type     lane_x_in, lane_y_in;

   always_comb begin
      dvd_x = {s4_nx_ff, {FRAC_BITS{1'b0}}};
      dvd_y = {s4_ny_ff, {FRAC_BITS{1'b0}}};
      hi_x  = dvd_x[DVD_W-1:DIV_Q_W];
      hi_y  = dvd_y[DVD_W-1:DIV_Q_W];
      // quotient of 2^33 or more can only saturate
      lane_x_in.ovf = MAG_W'(hi_x) >= s4_side_ff.den;
      lane_y_in.ovf = MAG_W'(hi_y) >= s4_side_ff.den;
      lane_x_in.rem = lane_x_in.ovf ? '0 : REM_W'(hi_x);
      lane_y_in.rem = lane_y_in.ovf ? '0 : REM_W'(hi_y);
      lane_x_in.quo = '0;
      lane_y_in.quo = '0;
      lane_x_in.low = dvd_x[DIV_Q_W-1:0];
      lane_y_in.low = dvd_y[DIV_Q_W-1:0];
      lane_x_in.neg = s4_negx_ff;
      lane_y_in.neg = s4_negy_ff;
   end

   logic [DIV_STEPS:0] vld_ff;
   div_lane_type       lx_ff [DIV_STEPS+1];
   div_lane_type       ly_ff [DIV_STEPS+1];
   side_type           side_ff [DIV_STEPS+1];

   always_ff @(posedge clock) begin
      if (reset) vld_ff[0] <= 1'b0;
      else if (adv) vld_ff[0] <= s4_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lx_ff[0]   <= lane_x_in;
         ly_ff[0]   <= lane_y_in;
         side_ff[0] <= s4_side_ff;
      end
   end

   // ---------------- restoring divider, one quotient bit per stage -------
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      div_lane_type lx_in, ly_in;
      logic [REM_W-1:0] rx_sh, ry_sh, den_ext;

      always_comb begin
         den_ext = REM_W'(side_ff[k].den);
         rx_sh   = {lx_ff[k].rem[REM_W-2:0], lx_ff[k].low[DIV_Q_W-1]};
         ry_sh   = {ly_ff[k].rem[REM_W-2:0], ly_ff[k].low[DIV_Q_W-1]};
         lx_in   = lx_ff[k];
         ly_in   = ly_ff[k];
         lx_in.low = lx_ff[k].low << 1;
         ly_in.low = ly_ff[k].low << 1;
         if (rx_sh >= den_ext) begin
            lx_in.rem = rx_sh - den_ext;
            lx_in.quo = {lx_ff[k].quo[DIV_Q_W-2:0], 1'b1};
         end else begin
            lx_in.rem = rx_sh;
            lx_in.quo = {lx_ff[k].quo[DIV_Q_W-2:0], 1'b0};
         end
         if (ry_sh >= den_ext) begin
            ly_in.rem = ry_sh - den_ext;
            ly_in.quo = {ly_ff[k].quo[DIV_Q_W-2:0], 1'b1};
         end else begin
            ly_in.rem = ry_sh;
            ly_in.quo = {ly_ff[k].quo[DIV_Q_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) vld_ff[k+1] <= 1'b0;
         else if (adv) vld_ff[k+1] <= vld_ff[k];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            lx_ff[k+1]   <= lx_in;
            ly_ff[k+1]   <= ly_in;
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   // ---------------- result selection and output register ---------------
   localparam logic [DIV_Q_W-1:0] Q_NEG_LIM = DIV_Q_W'(1) << (WORD_W - 1);
   localparam logic [DIV_Q_W-1:0] Q_POS_LIM = Q_NEG_LIM - DIV_Q_W'(1);

   side_type          side_end;
   div_lane_type      lx_end, ly_end;
   logic [WORD_W-1:0] qx_word, qy_word, res_x, res_y;
   logic              qx_sat, qy_sat;
   status_type        res_status;

   always_comb begin
      side_end = side_ff[DIV_STEPS];
      lx_end   = lx_ff[DIV_STEPS];
      ly_end   = ly_ff[DIV_STEPS];
      qx_sat   = lx_end.ovf || (lx_end.neg ? lx_end.quo > Q_NEG_LIM : lx_end.quo > Q_POS_LIM);
      qy_sat   = ly_end.ovf || (ly_end.neg ? ly_end.quo > Q_NEG_LIM : ly_end.quo > Q_POS_LIM);
      if (qx_sat) qx_word = lx_end.neg ? SAT_MIN[WORD_W-1:0] : SAT_MAX[WORD_W-1:0];
      else        qx_word = lx_end.neg ? WORD_W'(-lx_end.quo) : lx_end.quo[WORD_W-1:0];
      if (qy_sat) qy_word = ly_end.neg ? SAT_MIN[WORD_W-1:0] : SAT_MAX[WORD_W-1:0];
      else        qy_word = ly_end.neg ? WORD_W'(-ly_end.quo) : ly_end.quo[WORD_W-1:0];

      if (side_end.func) begin
         res_x      = side_end.off_x;
         res_y      = side_end.off_y;
         res_status = side_end.off_sat ? STATUS_SAT : STATUS_OK;
      end else if (side_end.det_zero) begin
         res_x      = '0;
         res_y      = '0;
         res_status = STATUS_NO_CAL;
      end else begin
         res_x      = qx_word;
         res_y      = qy_word;
         res_status = (side_end.sat_pre || qx_sat || qy_sat) ? STATUS_SAT : STATUS_OK;
      end
   end

   logic [WORD_W-1:0] out_x_ff, out_y_ff;
   status_type        out_status_ff;

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (adv) out_valid_ff <= vld_ff[DIV_STEPS];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_x_ff      <= res_x;
         out_y_ff      <= res_y;
         out_status_ff <= res_status;
      end
   end

   assign rsp_bus.valid    = out_valid_ff;
   assign rsp_bus.result_x = out_x_ff;
   assign rsp_bus.result_y = out_y_ff;
   assign rsp_bus.status   = out_status_ff;

   // ---------------- assertions ----------------
   // no calibration always comes with zeroed results
   a_nocal_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.status == STATUS_NO_CAL |->
         rsp_bus.result_x == '0 && rsp_bus.result_y == '0)
      else $error("no-calibration result not zero");

   // a divider entry moves one stage on each advance
   a_div_move: assert property (@(posedge clock) disable iff (reset)
      adv && vld_ff[0] |=> vld_ff[1])
      else $error("divider stage lost a request");

   // hold the stage 1, stage 4 and divider valid bits while the response stalls
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff) && $stable(s1_valid_ff) && $stable(s4_valid_ff))
      else $error("pipeline moved during a stall");

   // an x-lane divider overflow on a valid correction must flag saturation
   a_ovf_flag: assert property (@(posedge clock) disable iff (reset)
      vld_ff[DIV_STEPS] && !side_end.func && !side_end.det_zero && lx_end.ovf |->
         res_status == STATUS_SAT)
      else $error("overflow without saturation status");

endmodule
